/* src/gps_track_raster_plotter_top_assert.svh */
// Assertion macros shared by the plotter modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GPS_TRACK_RASTER_PLOTTER_TOP_ASSERT_SVH
`define GPS_TRACK_RASTER_PLOTTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GTRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GTRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GTRP_ASSERT(lbl, prop, msg)
`define GTRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/gtrp_pkg.sv */
// Shared types and constants of the GPS track raster plotter.
// No dependencies.
`timescale 1ns / 1ps
package gtrp_pkg;

  // input commands
  localparam logic [1:0] CMD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_NEXT   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_SKIP   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CENTER_LON   = 3'd0;
  localparam logic [2:0] REG_CENTER_LAT   = 3'd1;
  localparam logic [2:0] REG_VIEW_RADIUS  = 3'd2;
  localparam logic [2:0] REG_FRAME_LEFT   = 3'd3;
  localparam logic [2:0] REG_FRAME_TOP    = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

  localparam int INSET      = 5;
  localparam int COORD_BITS = 11;
  localparam logic [10:0] COORD_MASK = 11'((32'd1 << COORD_BITS) - 32'd1);
  localparam int DIV_STEPS  = 48;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
  } item_t;

  typedef struct packed {
    logic signed [31:0] center_lon;
    logic signed [30:0] center_lat;
    logic [29:0]        view_radius;
    logic [9:0]         frame_left;
    logic [9:0]         frame_top;
    logic [10:0]        frame_width;
    logic [10:0]        frame_height;
  } cfg_t;

endpackage

/* src/gtrp_front.sv */
// Front end: accepts track items, drops unknown commands, queues the rest.
// Depends on gtrp_pkg.
`timescale 1ns / 1ps
`include "gps_track_raster_plotter_top_assert.svh"
module gtrp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [30:0] in_point_lat,
  input  logic signed [31:0] in_point_lon,
  output gtrp_pkg::item_t    head,
  output logic               head_valid,
  input  logic               pop
);
  import gtrp_pkg::*;

  item_t       mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        push, accept;

  assign in_stall   = (count_r == 2'd2);
  assign accept     = in_valid && !in_stall;
  assign push       = accept && (in_command != CMD_SKIP);
  assign head       = mem_r[rptr_r];
  assign head_valid = (count_r != 2'd0);

  // count entries
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) wptr_r <= !wptr_r;
      if (pop) rptr_r <= !rptr_r;
    end
  end

  // store item
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= '{cmd: in_command, lat: in_point_lat, lon: in_point_lon};
  end

  `GTRP_ASSERT(a_pop_nonempty, pop |-> count_r != 2'd0, "pop from empty queue")
  `GTRP_ASSERT(a_count_bound, count_r <= 2'd2, "queue count overflow")
  `GTRP_ASSERT(a_skip_dropped, (accept && in_command == CMD_SKIP && !pop) |=> count_r == $past(count_r), "unknown command queued")
endmodule

/* src/gtrp_back.sv */
// Back end: scales a queued point, updates track state, emits draw items.
// Depends on gtrp_pkg; one shared multiply stage and a radix-2 divider.
`timescale 1ns / 1ps
`include "gps_track_raster_plotter_top_assert.svh"
module gtrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gtrp_pkg::cfg_t   cfg,
  input  gtrp_pkg::item_t  head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [10:0]      out_x_start,
  output logic [10:0]      out_y_start,
  output logic [10:0]      out_x_end,
  output logic [10:0]      out_y_end,
  output logic             out_last
);
  import gtrp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
                                                input logic signed [12:0] lo,
                                                input logic signed [12:0] hi);
    logic signed [15:0] r;
    r = v;
    if (v < 16'(lo)) r = 16'(lo);
    else if (v > 16'(hi)) r = 16'(hi);
    return r;
  endfunction

  logic [2:0]          state_r;
  item_t               item_r;
  logic                axis_r;
  logic signed [48:0]  num_r;
  logic                neg_r;
  logic [47:0]         dvd_r;
  logic [30:0]         rem_r;
  logic [5:0]          cnt_r;
  logic signed [15:0]  x_r, y_r;
  logic signed [15:0]  prev_x_r, prev_y_r;
  logic                prz_r, have_r;
  logic [5:0]          mask_r;
  logic signed [15:0]  lx0_r, ly0_r, lx1_r, ly1_r;
  logic                out_valid_r, out_kind_r, out_last_r;
  logic [10:0]         oxs_r, oys_r, oxe_r, oye_r;

  logic signed [12:0]  hmin, hmax, vmin, vmax, lo, span;
  logic [30:0]         den;
  logic signed [32:0]  v33, c33;
  logic signed [34:0]  d35;
  logic signed [48:0]  prod, lod;
  logic [31:0]         rem_sh;
  logic                qbit;
  logic signed [15:0]  s16;
  logic signed [17:0]  ysum;
  logic signed [15:0]  ysat;
  logic                in0, in1, fits, draw, mark_en;
  logic [5:0]          mask_nxt, lowest;
  logic                out_free;
  logic signed [15:0]  ex, ey;

  // window edges
  assign hmin = 13'($unsigned(cfg.frame_left)) + 13'(INSET);
  assign hmax = 13'($unsigned(cfg.frame_left)) + 13'($unsigned(cfg.frame_width)) - 13'(INSET + 1);
  assign vmin = 13'($unsigned(cfg.frame_top)) + 13'(INSET);
  assign vmax = 13'($unsigned(cfg.frame_top)) + 13'($unsigned(cfg.frame_height)) - 13'(INSET + 1);
  assign den  = {cfg.view_radius, 1'b0};

  // numerator of the current axis
  always_comb begin
    c33  = axis_r ? 33'(cfg.center_lat) : 33'(cfg.center_lon);
    v33  = axis_r ? 33'(item_r.lat) : 33'(item_r.lon);
    if (item_r.cmd == CMD_FINISH) v33 = c33;
    lo   = axis_r ? vmin : hmin;
    span = axis_r ? (vmax - vmin) : (hmax - hmin);
    d35  = 35'(v33) - 35'(c33) + $signed({5'b0, cfg.view_radius});
    prod = 49'(d35) * 49'(span);
    lod  = $signed({18'b0, den}) * 49'(lo);
  end

  // divider step
  assign rem_sh = {rem_r, dvd_r[47]};
  assign qbit   = (rem_sh >= {1'b0, den});

  // saturate the quotient
  always_comb begin
    if (den == 31'd0) s16 = 16'(lo);
    else if (!neg_r) s16 = (dvd_r > 48'd32767) ? 16'sh7fff : $signed(dvd_r[15:0]);
    else s16 = (dvd_r > 48'd32768) ? 16'sh8000 : $signed(16'(16'd0 - dvd_r[15:0]));
    ysum = 18'(vmin) + 18'(vmax) - 18'(s16);
    if (ysum > 18'sd32767) ysat = 16'sh7fff;
    else if (ysum < -18'sd32768) ysat = 16'sh8000;
    else ysat = ysum[15:0];
  end

  // classify the mapped point
  always_comb begin
    in0  = prev_x_r >= 16'(hmin) && prev_x_r <= 16'(hmax) &&
           prev_y_r >= 16'(vmin) && prev_y_r <= 16'(vmax);
    in1  = x_r >= 16'(hmin) && x_r <= 16'(hmax) && y_r >= 16'(vmin) && y_r <= 16'(vmax);
    fits = x_r > 16'(hmin) && x_r < 16'(hmax) && y_r > 16'(vmin) && y_r < 16'(vmax);
    draw = (item_r.cmd == CMD_NEXT) && have_r && !prz_r;
    mark_en = draw || (item_r.cmd == CMD_FINISH);
    mask_nxt[0]   = draw && (in0 || in1);
    mask_nxt[1]   = mark_en && (fits || in1);
    mask_nxt[5:2] = {4{mark_en && fits}};
  end

  // pick the next draw item
  assign lowest   = mask_r & (~mask_r + 6'd1);
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    ex = x_r;
    ey = y_r;
    case (lowest)
      6'b000100: ex = x_r - 16'sd1;
      6'b001000: ex = x_r + 16'sd1;
      6'b010000: ey = y_r - 16'sd1;
      6'b100000: ey = y_r + 16'sd1;
      default: ;
    endcase
  end

  assign pop = (state_r == S_IDLE) && head_valid;

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prz_r    <= 1'b0;
      have_r   <= 1'b0;
      mask_r   <= '0;
      axis_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (head_valid && !(head.cmd == CMD_FINISH && !have_r)) begin
            axis_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_ABS;
        S_ABS: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_STEPS - 1)) state_r <= S_SAT;
        end
        S_SAT: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_MUL;
          end else begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          mask_r <= mask_nxt;
          if (item_r.cmd == CMD_FINISH) begin
            have_r <= 1'b0;
          end else begin
            prev_x_r <= x_r;
            prev_y_r <= y_r;
            prz_r    <= (item_r.lat == '0) && (item_r.lon == '0);
            have_r   <= 1'b1;
          end
          state_r <= (mask_nxt == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            mask_r <= mask_r & ~lowest;
            if ((mask_r & ~lowest) == '0) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) item_r <= head;
    if (state_r == S_MUL) num_r <= prod + lod;
    if (state_r == S_ABS) begin
      neg_r <= num_r[48];
      dvd_r <= num_r[48] ? 48'(-num_r) : num_r[47:0];
      rem_r <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r <= qbit ? 31'(rem_sh - {1'b0, den}) : rem_sh[30:0];
      dvd_r <= {dvd_r[46:0], qbit};
    end
    if (state_r == S_SAT) begin
      if (!axis_r) x_r <= s16;
      else y_r <= ysat;
    end
    if (state_r == S_EVAL) begin
      lx0_r <= prev_x_r;
      ly0_r <= prev_y_r;
      lx1_r <= x_r;
      ly1_r <= y_r;
      if (in0 != in1) begin
        lx0_r <= clampv(prev_x_r, hmin, hmax);
        ly0_r <= clampv(prev_y_r, vmin, vmax);
        lx1_r <= clampv(x_r, hmin, hmax);
        ly1_r <= clampv(y_r, vmin, vmax);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= (state_r == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state_r == S_EMIT) begin
      out_last_r <= ((mask_r & ~lowest) == '0);
      if (lowest == 6'b000001) begin
        out_kind_r <= 1'b0;
        oxs_r <= lx0_r[10:0] & COORD_MASK;
        oys_r <= ly0_r[10:0] & COORD_MASK;
        oxe_r <= lx1_r[10:0] & COORD_MASK;
        oye_r <= ly1_r[10:0] & COORD_MASK;
      end else begin
        out_kind_r <= 1'b1;
        oxs_r <= ex[10:0] & COORD_MASK;
        oys_r <= ey[10:0] & COORD_MASK;
        oxe_r <= '0;
        oye_r <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_x_start = oxs_r;
  assign out_y_start = oys_r;
  assign out_x_end   = oxe_r;
  assign out_y_end   = oye_r;
  assign out_last    = out_last_r;

  `GTRP_ASSERT(a_div_count, state_r == S_DIV |-> cnt_r < 6'(DIV_STEPS), "divider count overrun")
  `GTRP_ASSERT(a_emit_mask, state_r == S_EMIT |-> mask_r != 6'd0, "emit state with empty mask")
  `GTRP_ASSERT(a_pixel_end, (out_valid_r && out_kind_r) |-> (oxe_r == '0 && oye_r == '0), "pixel item with end point")
endmodule

/* src/gps_track_raster_plotter_top.sv */
// From accept to the first draw item a point passes two axes, each a multiply, an abs
// step, a 48-step radix-2 divider and a saturate step; the back end shares this divider
// between both axes and takes a new point only once it is done with the last one.
// A two-entry queue takes new points while the back end works or the output stalls.
// Reset (rst_n, synchronous) restores register defaults and clears the track state.
`timescale 1ns / 1ps
module gps_track_raster_plotter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [30:0] in_point_lat,
  input  logic signed [31:0] in_point_lon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [10:0]        out_x_start,
  output logic [10:0]        out_y_start,
  output logic [10:0]        out_x_end,
  output logic [10:0]        out_y_end,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gtrp_pkg::*;

  cfg_t       cfg_r;
  item_t      head;
  logic       head_valid, pop;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_lon   <= '0;
      cfg_r.center_lat   <= '0;
      cfg_r.view_radius  <= 30'd10000;
      cfg_r.frame_left   <= '0;
      cfg_r.frame_top    <= '0;
      cfg_r.frame_width  <= 11'd128;
      cfg_r.frame_height <= 11'd64;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_CENTER_LON:   cfg_r.center_lon   <= pwdata;
        REG_CENTER_LAT:   cfg_r.center_lat   <= pwdata[30:0];
        REG_VIEW_RADIUS:  cfg_r.view_radius  <= pwdata[29:0];
        REG_FRAME_LEFT:   cfg_r.frame_left   <= pwdata[9:0];
        REG_FRAME_TOP:    cfg_r.frame_top    <= pwdata[9:0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[10:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_CENTER_LON:   prdata = cfg_r.center_lon;
      REG_CENTER_LAT:   prdata = 32'(cfg_r.center_lat);
      REG_VIEW_RADIUS:  prdata = {2'b0, cfg_r.view_radius};
      REG_FRAME_LEFT:   prdata = {22'b0, cfg_r.frame_left};
      REG_FRAME_TOP:    prdata = {22'b0, cfg_r.frame_top};
      REG_FRAME_WIDTH:  prdata = {21'b0, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {21'b0, cfg_r.frame_height};
      default:          prdata = '0;
    endcase
  end

  gtrp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_point_lat, .in_point_lon,
    .head, .head_valid, .pop
  );

  gtrp_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .head, .head_valid, .pop,
    .out_valid, .out_stall, .out_kind, .out_x_start, .out_y_start,
    .out_x_end, .out_y_end, .out_last
  );
endmodule

/* verif/gps_track_raster_plotter_top_test.sv */
// Self-checking testbench of the GPS track raster plotter top level.
// Depends on gtrp_pkg and gps_track_raster_plotter_top; holds its own plot predictor.
`timescale 1ns / 1ps
module gps_track_raster_plotter_top_test;
  import gtrp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [10:0] xs;
    logic [10:0] ys;
    logic [10:0] xe;
    logic [10:0] ye;
    logic        last;
  } draw_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic signed [30:0] in_point_lat;
  logic signed [31:0] in_point_lon;
  logic               out_valid;
  logic               out_stall;
  logic               out_kind;
  logic [10:0]        out_x_start;
  logic [10:0]        out_y_start;
  logic [10:0]        out_x_end;
  logic [10:0]        out_y_end;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  item_t  point_queue[$];
  draw_t  draw_queue[$];
  int     fail_count;
  bit     quiet;
  int     send_gap;
  int     recv_gap;
  int     hold_off;

  // predictor copy of registers and track state
  longint p_lon, p_lat, p_rad, p_left, p_top, p_width, p_height;
  longint last_x, last_y;
  bit     last_zero, tracking;

  gps_track_raster_plotter_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint scale_axis(longint v, longint ctr, longint lo, longint hi);
    longint den;
    den = 2 * p_rad;
    if (den == 0) return sat16(lo);
    return sat16(((v - ctr + p_rad) * (hi - lo) + lo * den) / den);
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void add_draw(bit kind, longint xs, longint ys, longint xe, longint ye);
    draw_t d;
    d.kind = kind;
    d.xs = xs[10:0];
    d.ys = ys[10:0];
    d.xe = xe[10:0];
    d.ye = ye[10:0];
    d.last = 1'b0;
    draw_queue.push_back(d);
  endfunction

  // cross when the 3x3 area fits, else a lone pixel when inside
  function automatic void add_mark(longint x, longint y, longint hmin, longint hmax,
                                   longint vmin, longint vmax);
    if (x - 1 < hmin || x + 1 > hmax || y - 1 < vmin || y + 1 > vmax) begin
      if (x >= hmin && x <= hmax && y >= vmin && y <= vmax) add_draw(1, x, y, 0, 0);
    end else begin
      add_draw(1, x, y, 0, 0);
      add_draw(1, x - 1, y, 0, 0);
      add_draw(1, x + 1, y, 0, 0);
      add_draw(1, x, y - 1, 0, 0);
      add_draw(1, x, y + 1, 0, 0);
    end
  endfunction

  // work out the draw items of one accepted point
  function automatic void plot_point(logic [1:0] cmd, logic signed [30:0] lat,
                                     logic signed [31:0] lon);
    longint hmin, hmax, vmin, vmax, x, y, x0, y0, x1, y1;
    int     before_n;
    bit     in0, in1;
    hmin = p_left + INSET;
    hmax = p_left + p_width - INSET - 1;
    vmin = p_top + INSET;
    vmax = p_top + p_height - INSET - 1;
    before_n = draw_queue.size();
    if (cmd == CMD_SKIP) return;
    if (cmd == CMD_FINISH) begin
      if (!tracking) return;
      tracking = 0;
      x = scale_axis(p_lon, p_lon, hmin, hmax);
      y = sat16(vmin + vmax - scale_axis(p_lat, p_lat, vmin, vmax));
      add_mark(x, y, hmin, hmax, vmin, vmax);
    end else begin
      x = scale_axis(longint'(lon), p_lon, hmin, hmax);
      y = sat16(vmin + vmax - scale_axis(longint'(lat), p_lat, vmin, vmax));
      if (cmd == CMD_NEXT && tracking && !last_zero) begin
        in0 = last_x >= hmin && last_x <= hmax && last_y >= vmin && last_y <= vmax;
        in1 = x >= hmin && x <= hmax && y >= vmin && y <= vmax;
        if (in0 || in1) begin
          x0 = last_x; y0 = last_y; x1 = x; y1 = y;
          if (in0 != in1) begin
            x0 = clampv(x0, hmin, hmax);
            y0 = clampv(y0, vmin, vmax);
            x1 = clampv(x1, hmin, hmax);
            y1 = clampv(y1, vmin, vmax);
          end
          add_draw(0, x0, y0, x1, y1);
        end
        add_mark(x, y, hmin, hmax, vmin, vmax);
      end
      last_x = x;
      last_y = y;
      last_zero = (lat == 0 && lon == 0);
      tracking = 1;
    end
    if (draw_queue.size() > before_n) draw_queue[draw_queue.size() - 1].last = 1'b1;
  endfunction

  // drive points, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        plot_point(in_command, in_point_lat, in_point_lon);
        void'(point_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_command <= point_queue[0].cmd;
          in_point_lat <= point_queue[0].lat;
          in_point_lon <= point_queue[0].lon;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // stall the result side in bursts, plus one long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each draw item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (draw_queue.size() == 0) begin
        $display("%0t: unexpected item kind=%0d x0=%0d y0=%0d x1=%0d y1=%0d last=%0d",
                 $time, out_kind, out_x_start, out_y_start, out_x_end, out_y_end, out_last);
        fail_count++;
      end else begin
        if (out_kind !== draw_queue[0].kind) begin
          $display("%0t: kind expected %0d got %0d", $time, draw_queue[0].kind, out_kind);
          fail_count++;
        end
        if (out_x_start !== draw_queue[0].xs) begin
          $display("%0t: x_start expected %0d got %0d", $time, draw_queue[0].xs, out_x_start);
          fail_count++;
        end
        if (out_y_start !== draw_queue[0].ys) begin
          $display("%0t: y_start expected %0d got %0d", $time, draw_queue[0].ys, out_y_start);
          fail_count++;
        end
        if (out_x_end !== draw_queue[0].xe) begin
          $display("%0t: x_end expected %0d got %0d", $time, draw_queue[0].xe, out_x_end);
          fail_count++;
        end
        if (out_y_end !== draw_queue[0].ye) begin
          $display("%0t: y_end expected %0d got %0d", $time, draw_queue[0].ye, out_y_end);
          fail_count++;
        end
        if (out_last !== draw_queue[0].last) begin
          $display("%0t: last expected %0d got %0d", $time, draw_queue[0].last, out_last);
          fail_count++;
        end
        void'(draw_queue.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (point_queue.size() > 0 || in_valid || draw_queue.size() > 0) @(posedge clk);
    // up to three points may still be in flight without causing any item
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value[31:0];
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CENTER_LON:   p_lon = longint'($signed(value[31:0]));
      REG_CENTER_LAT:   p_lat = longint'($signed(value[30:0]));
      REG_VIEW_RADIUS:  p_rad = value & 64'h3FFF_FFFF;
      REG_FRAME_LEFT:   p_left = value & 64'h3FF;
      REG_FRAME_TOP:    p_top = value & 64'h3FF;
      REG_FRAME_WIDTH:  p_width = value & 64'h7FF;
      REG_FRAME_HEIGHT: p_height = value & 64'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_view(longint lon, longint lat, longint rad, longint left, longint top,
                          longint width, longint height);
    @(posedge clk);
    write_reg(REG_CENTER_LON, lon);
    write_reg(REG_CENTER_LAT, lat);
    write_reg(REG_VIEW_RADIUS, rad);
    write_reg(REG_FRAME_LEFT, left);
    write_reg(REG_FRAME_TOP, top);
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
  endtask

  function automatic void add_point(logic [1:0] cmd, longint lat, longint lon);
    item_t it;
    it.cmd = cmd;
    it.lat = lat[30:0];
    it.lon = lon[31:0];
    point_queue.push_back(it);
  endfunction

  // a coordinate near the view, sometimes well outside it
  function automatic longint near_view(longint ctr, longint lim);
    longint r, v;
    r = (p_rad == 0) ? 1000 : p_rad;
    if (r > 900000000) r = 900000000;
    v = ctr - 2 * r + longint'($urandom_range(0, 32'(4 * r)));
    return clampv(v, -lim, lim);
  endfunction

  // random tracks with noise mixed in
  function automatic void add_tracks(int count);
    int n, k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        add_point(2'($urandom_range(0, 3)),
                  longint'($urandom_range(0, 1800000000)) - 900000000,
                  longint'($urandom_range(0, 3600000000)) - 1800000000);
        n++;
      end else begin
        add_point(CMD_FIRST, near_view(p_lat, 900000000), near_view(p_lon, 1800000000));
        n++;
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 9) == 0) add_point(CMD_NEXT, 0, 0);
          else add_point(CMD_NEXT, near_view(p_lat, 900000000), near_view(p_lon, 1800000000));
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          add_point(CMD_FINISH, $urandom_range(0, 100), $urandom_range(0, 100));
          n++;
        end
      end
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_FIRST;
    in_point_lat = '0;
    in_point_lon = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    quiet = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_off = 0;
    p_lon = 0; p_lat = 0; p_rad = 10000;
    p_left = 0; p_top = 0; p_width = 128; p_height = 64;
    last_x = 0; last_y = 0; last_zero = 0; tracking = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default view, special cases and field extremes
    add_point(CMD_FINISH, 0, 0);
    add_point(CMD_NEXT, 3000, -2000);
    add_point(CMD_NEXT, 0, 0);
    add_point(CMD_NEXT, 5000, 5000);
    add_point(CMD_NEXT, 9000, -9000);
    add_point(CMD_NEXT, 50000, 50000);
    add_point(CMD_NEXT, -50000, -50000);
    add_point(CMD_NEXT, -2000, 1000);
    add_point(CMD_SKIP, 123, 456);
    add_point(CMD_FINISH, 0, 0);
    add_point(CMD_FINISH, 0, 0);
    add_point(CMD_FIRST, 900000000, 1800000000);
    add_point(CMD_NEXT, -900000000, -1800000000);
    add_point(CMD_NEXT, 10000, 10000);
    add_point(CMD_NEXT, -9999, -10000);
    add_point(CMD_FINISH, -1, -1);
    add_point(CMD_FIRST, -1, -1);
    add_point(CMD_NEXT, 1, 1);
    add_point(CMD_FINISH, 0, 0);
    wait_drained();

    // extreme views: tiny radius with a huge frame at the far corner, then a huge radius with a minimal frame
    set_view(1800000000, 900000000, 1, 1023, 1023, 1024, 1024);
    add_tracks(25);
    wait_drained();
    set_view(-1800000000, -900000000, 900000000, 0, 0, 11, 11);
    add_tracks(25);
    wait_drained();
    // zero radius and a window too small to draw in
    set_view(12345, -6789, 0, 100, 200, 300, 200);
    add_tracks(20);
    wait_drained();
    set_view(0, 0, 20000, 7, 9, 10, 3);
    add_tracks(15);
    wait_drained();

    // long receiver hold-off while points keep coming
    set_view(0, 0, 10000, 0, 0, 128, 64);
    hold_off = 600;
    add_tracks(30);
    wait_drained();

    repeat (3) begin
      set_view(longint'($urandom_range(0, 3600000000)) - 1800000000,
               longint'($urandom_range(0, 1800000000)) - 900000000,
               $urandom_range(1, 5000000), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(11, 1024), $urandom_range(11, 1024));
      add_tracks(50);
      wait_drained();
    end

    // last stretch without idling
    set_view(0, 0, 50000, 20, 30, 640, 480);
    quiet = 1;
    add_tracks(40);
    wait_drained();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
